[rtl/core/tkcf_pkg.sv]
package tkcf_pkg;

   // build options
   localparam int CORDIC_STEPS = 20;
   localparam logic [16:0] ABS_ETA_MIN = 17'd0;
   localparam logic [16:0] ABS_ETA_MAX = 17'd32768;
   localparam logic KEEP_NEUTRAL = 1'b1;

   // datapath widths: CORDIC x/y, CORDIC angle, log sums
   localparam int XW = 54;
   localparam int ZW = 36;
   localparam int LW = 42;

   // last step of the multiply sequence and of the normalizer
   localparam logic [4:0] MUL_LAST = 5'd9;
   localparam logic [4:0] NORM_LAST = 5'd5;

   // register indexes
   localparam logic [3:0] CSR_RHO_MAX = 4'd0;
   localparam logic [3:0] CSR_ABS_Z_MAX = 4'd1;
   localparam logic [3:0] CSR_PHI_MIN = 4'd2;
   localparam logic [3:0] CSR_PHI_MAX = 4'd3;
   localparam logic [3:0] CSR_ETA_MIN = 4'd4;
   localparam logic [3:0] CSR_ETA_MAX = 4'd5;
   localparam logic [3:0] CSR_PT_MIN = 4'd6;
   localparam logic [3:0] CSR_PT_MAX = 4'd7;

   // fixed point constants, Q30
   localparam logic [31:0] K_Q30 = 32'd1768195363;
   localparam logic [31:0] K2_Q30 = 32'd2911793853;
   localparam logic signed [LW-1:0] LN2_Q30 = 42'sd744261118;
   localparam logic signed [LW-1:0] LNK_Q30 = 42'sd535593028;
   localparam logic signed [XW-1:0] ONE_X = 54'sd1073741824;
   localparam logic signed [ZW-1:0] ONE_Z = 36'sd1073741824;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] mom_x;
      logic signed [31:0] mom_y;
      logic signed [31:0] mom_z;
      logic signed [3:0]  charge;
      logic               last_of_vertex;
   } item_type;

   typedef struct packed {
      logic keep;
      logic vertex_kept;
      logic vertex_end;
   } result_type;

   typedef struct packed {
      logic [31:0]        rho_max;
      logic [31:0]        abs_z_max;
      logic signed [16:0] phi_min;
      logic signed [16:0] phi_max;
      logic signed [16:0] eta_min;
      logic signed [16:0] eta_max;
      logic [31:0]        pt_min;
      logic [31:0]        pt_max;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_CIRC_PHI,
      ST_LOAD_P,
      ST_CIRC_P,
      ST_LOAD_LN,
      ST_NORM,
      ST_LOAD_HYP,
      ST_HYP,
      ST_LN_DONE,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic        load;
      logic        step;
      logic        hyp;
      logic [5:0]  shift;
      logic [29:0] angle;
   } cordic_cmd_type;

   // magnitude of a 32 bit signed value
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   // atan(2^-i) in units of pi/2^30
   function automatic logic [29:0] atan_angle(input logic [4:0] i);
      logic [29:0] a;
      unique case (i)
         5'd0:  a = 30'd268435456;
         5'd1:  a = 30'd158466703;
         5'd2:  a = 30'd83729454;
         5'd3:  a = 30'd42502378;
         5'd4:  a = 30'd21333666;
         5'd5:  a = 30'd10677233;
         5'd6:  a = 30'd5339919;
         5'd7:  a = 30'd2670123;
         5'd8:  a = 30'd1335082;
         5'd9:  a = 30'd667543;
         5'd10: a = 30'd333772;
         5'd11: a = 30'd166886;
         5'd12: a = 30'd83443;
         5'd13: a = 30'd41722;
         5'd14: a = 30'd20861;
         5'd15: a = 30'd10430;
         5'd16: a = 30'd5215;
         5'd17: a = 30'd2608;
         5'd18: a = 30'd1304;
         5'd19: a = 30'd652;
         5'd20: a = 30'd326;
         5'd21: a = 30'd163;
         5'd22: a = 30'd81;
         5'd23: a = 30'd41;
         5'd24: a = 30'd20;
         5'd25: a = 30'd10;
         5'd26: a = 30'd5;
         5'd27: a = 30'd3;
         5'd28: a = 30'd1;
         5'd29: a = 30'd1;
         default: a = 30'd0;
      endcase
      return a;
   endfunction

   // atanh(2^-i) in Q30; beyond the table it equals 2^-i
   function automatic logic [29:0] hyp_angle(input logic [5:0] i);
      logic [29:0] a;
      unique case (i)
         6'd1:  a = 30'd589812981;
         6'd2:  a = 30'd274247419;
         6'd3:  a = 30'd134923406;
         6'd4:  a = 30'd67196451;
         6'd5:  a = 30'd33565361;
         6'd6:  a = 30'd16778582;
         6'd7:  a = 30'd8388779;
         6'd8:  a = 30'd4194325;
         6'd9:  a = 30'd2097155;
         6'd10: a = 30'd1048576;
         default: a = (i <= 6'd30 && i != 6'd0) ? (30'd1 << (6'd30 - i)) : 30'd0;
      endcase
      return a;
   endfunction

endpackage

[rtl/core/track_kinematic_cut_filter.sv]
// Track kinematic cut filter.
// Input channel req_*: one track per item (position, momentum, charge and
// end-of-vertex mark); accepted when req_valid is high and req_stall low.
// Result channel rsp_*: one item per track with keep, vertex_kept and
// vertex_end, same valid/stall handshake.
// Configuration: csr_write_en writes csr_wdata into the cut register named
// by csr_index; unknown indexes are ignored. Write only while idle.
// A two-entry queue takes tracks while the engine works. The engine runs
// one track at a time: it picks the track up, runs the multiply sequence on
// the shared 32x32 multiplier, makes two circular CORDIC passes with a reload
// between them, takes two logarithms (normalize, hyperbolic steps, finish)
// and emits the result. It takes the next track from the queue only after
// emitting the last, and all passes share the single CORDIC unit. Tracks with
// zero transverse momentum skip the CORDIC work.
// Reset clears the queue, the output slot and the vertex record and loads
// the default cut windows. While rsp_stall is high the result holds; the
// engine waits with the next result and the queue fills, then req_stall
// rises.
module track_kinematic_cut_filter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tkcf_pkg::item_type   req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tkcf_pkg::result_type rsp_payload,
   input  logic                 csr_write_en,
   input  logic [3:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   import tkcf_pkg::*;

   cfg_type  cfg_ff;
   logic     q_valid, q_pop;
   item_type q_item;

   // cut registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rho_max <= 32'hFFFF_FFFF;
         cfg_ff.abs_z_max <= 32'h8000_0000;
         cfg_ff.phi_min <= -17'sd32768;
         cfg_ff.phi_max <= 17'sd32768;
         cfg_ff.eta_min <= -17'sd32768;
         cfg_ff.eta_max <= 17'sd32768;
         cfg_ff.pt_min <= 32'd0;
         cfg_ff.pt_max <= 32'hFFFF_FFFF;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_RHO_MAX:   cfg_ff.rho_max <= csr_wdata;
            CSR_ABS_Z_MAX: cfg_ff.abs_z_max <= csr_wdata;
            CSR_PHI_MIN:   cfg_ff.phi_min <= csr_wdata[16:0];
            CSR_PHI_MAX:   cfg_ff.phi_max <= csr_wdata[16:0];
            CSR_ETA_MIN:   cfg_ff.eta_min <= csr_wdata[16:0];
            CSR_ETA_MAX:   cfg_ff.eta_max <= csr_wdata[16:0];
            CSR_PT_MIN:    cfg_ff.pt_min <= csr_wdata;
            CSR_PT_MAX:    cfg_ff.pt_max <= csr_wdata;
            default: ;
         endcase
      end
   end

   tkcf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   tkcf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/core/tkcf_front.sv]
module tkcf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tkcf_pkg::item_type req_payload,
   output logic               q_valid,
   output tkcf_pkg::item_type q_item,
   input  logic               q_pop
);
   import tkcf_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (count_ff != 2'd0);
   assign q_item = mem_ff[rd_ptr_ff];

   // store accepted items
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_payload;
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !q_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (q_pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != 2'd0) else $error("pop from empty queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("push did not grow queue");

endmodule

[rtl/core/tkcf_cordic.sv]
module tkcf_cordic (
   input  logic                                 clock,
   input  tkcf_pkg::cordic_cmd_type             cmd,
   input  logic signed [tkcf_pkg::XW-1:0]       ld_x,
   input  logic signed [tkcf_pkg::XW-1:0]       ld_y,
   input  logic signed [tkcf_pkg::ZW-1:0]       ld_z,
   output logic signed [tkcf_pkg::XW-1:0]       c_x,
   output logic signed [tkcf_pkg::XW-1:0]       c_y,
   output logic signed [tkcf_pkg::ZW-1:0]       c_z
);
   import tkcf_pkg::*;

   logic signed [XW-1:0] x_ff, y_ff, dx, dy;
   logic signed [ZW-1:0] z_ff, ang;

   assign dx = y_ff >>> cmd.shift;
   assign dy = x_ff >>> cmd.shift;
   assign ang = signed'({{(ZW-30){1'b0}}, cmd.angle});
   assign c_x = x_ff;
   assign c_y = y_ff;
   assign c_z = z_ff;

   // one rotation step per cycle while cmd.step is set, circular or hyperbolic
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= ld_x;
         y_ff <= ld_y;
         z_ff <= ld_z;
      end else if (cmd.step) begin
         if (!y_ff[XW-1]) begin
            x_ff <= cmd.hyp ? x_ff - dx : x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + ang;
         end else begin
            x_ff <= cmd.hyp ? x_ff + dx : x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - ang;
         end
      end
   end

endmodule

[rtl/core/tkcf_back.sv]
module tkcf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tkcf_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   input  tkcf_pkg::item_type   q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tkcf_pkg::result_type rsp_payload
);
   import tkcf_pkg::*;

   back_state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [5:0] idx_ff, idx_in;
   logic       rep_ff, rep_in;
   logic       pass_ff, pass_in;
   logic       emit;

   item_type item_ff;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_ff, srho_ff, spt_ff, rho2_ff, ptmin2_ff, ptmax2_ff;
   logic [49:0] azk_ff, azk2_ff;
   logic signed [16:0] phi_ff, eta_ff;
   logic eta_ok_ff;
   logic signed [XW-1:0] x1_ff;
   logic [63:0] norm_ff;
   logic [5:0]  m_ff;
   logic signed [LW-1:0] ln_a_ff;

   cordic_cmd_type cmd;
   logic signed [XW-1:0] ld_x, ld_y, c_x, c_y;
   logic signed [ZW-1:0] ld_z, c_z;

   logic rsp_valid_ff, any_kept_ff;
   result_type rsp_payload_ff;

   logic pt_nz, neg_x;
   logic signed [XW-1:0] px_sh, py_sh, circ_x0, circ_y0, hyp_x0, hyp_y0;
   logic signed [ZW-1:0] circ_z0, phi_sum, phi_sh;
   logic signed [16:0] phi_calc, eta_calc;
   logic signed [LW-1:0] ln_val, lmag, eta_r;
   logic [16:0] aeta_c, aeta;
   logic [30:0] w;
   logic keep_c, any_next;

   tkcf_cordic u_cordic (
      .clock (clock),
      .cmd   (cmd),
      .ld_x  (ld_x),
      .ld_y  (ld_y),
      .ld_z  (ld_z),
      .c_x   (c_x),
      .c_y   (c_y),
      .c_z   (c_z)
   );

   // start vector for the azimuth: fold into the right half plane
   assign pt_nz = (item_ff.mom_x != 32'sd0) || (item_ff.mom_y != 32'sd0);
   assign neg_x = item_ff.mom_x[31];
   assign px_sh = {{(XW-32){item_ff.mom_x[31]}}, item_ff.mom_x} <<< 16;
   assign py_sh = {{(XW-32){item_ff.mom_y[31]}}, item_ff.mom_y} <<< 16;
   assign circ_x0 = neg_x ? -px_sh : px_sh;
   assign circ_y0 = neg_x ? -py_sh : py_sh;
   assign circ_z0 = neg_x ? (item_ff.mom_y[31] ? -ONE_Z : ONE_Z) : '0;

   // hyperbolic start from the normalized mantissa
   assign w = norm_ff[63:33];
   assign hyp_x0 = signed'({{(XW-31){1'b0}}, w}) + ONE_X;
   assign hyp_y0 = signed'({{(XW-31){1'b0}}, w}) - ONE_X;

   // round and clamp the azimuth
   assign phi_sum = c_z + 36'sd16384;
   assign phi_sh = phi_sum >>> 15;
   always_comb begin
      if (phi_sh > 36'sd32768) begin
         phi_calc = 17'sd32768;
      end else if (phi_sh < -36'sd32768) begin
         phi_calc = -17'sd32768;
      end else begin
         phi_calc = phi_sh[16:0];
      end
   end

   // log, log difference and eta rounding
   assign ln_val = $signed(LW'(m_ff)) * LN2_Q30 + (LW'(c_z) <<< 1);
   assign lmag = ln_a_ff - ln_val - LNK_Q30;
   assign eta_r = (lmag + 42'sd262144) >>> 19;
   always_comb begin
      if (eta_r < 42'sd0) begin
         aeta_c = 17'd0;
      end else if (eta_r > 42'sd32768) begin
         aeta_c = 17'd32768;
      end else begin
         aeta_c = eta_r[16:0];
      end
      eta_calc = item_ff.mom_z[31] ? -signed'(aeta_c) : signed'(aeta_c);
   end

   // multiply sequence operands
   always_comb begin
      unique case (cnt_ff)
         5'd0: begin mul_a = mag32(item_ff.pos_x); mul_b = mag32(item_ff.pos_x); end
         5'd1: begin mul_a = mag32(item_ff.pos_y); mul_b = mag32(item_ff.pos_y); end
         5'd2: begin mul_a = mag32(item_ff.mom_x); mul_b = mag32(item_ff.mom_x); end
         5'd3: begin mul_a = mag32(item_ff.mom_y); mul_b = mag32(item_ff.mom_y); end
         5'd4: begin mul_a = cfg.rho_max; mul_b = cfg.rho_max; end
         5'd5: begin mul_a = cfg.pt_min; mul_b = cfg.pt_min; end
         5'd6: begin mul_a = cfg.pt_max; mul_b = cfg.pt_max; end
         5'd7: begin mul_a = mag32(item_ff.mom_z); mul_b = K_Q30; end
         5'd8: begin mul_a = mag32(item_ff.mom_z); mul_b = K2_Q30; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // cut decision
   assign aeta = eta_ff[16] ? 17'(-eta_ff) : 17'(eta_ff);
   assign keep_c = (srho_ff < rho2_ff)
      && (mag32(item_ff.pos_z) < cfg.abs_z_max)
      && (cfg.phi_min <= phi_ff) && (phi_ff < cfg.phi_max)
      && eta_ok_ff
      && (cfg.eta_min <= eta_ff) && (eta_ff < cfg.eta_max)
      && (aeta >= ABS_ETA_MIN) && (aeta < ABS_ETA_MAX)
      && (ptmin2_ff <= spt_ff) && (spt_ff < ptmax2_ff)
      && (KEEP_NEUTRAL || (item_ff.charge != 4'sd0));
   assign any_next = any_kept_ff || keep_c;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      rep_in = rep_ff;
      pass_in = pass_ff;
      q_pop = 1'b0;
      emit = 1'b0;
      cmd = '0;
      ld_x = '0;
      ld_y = '0;
      ld_z = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               cnt_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in = '0;
               if (pt_nz) begin
                  cmd.load = 1'b1;
                  ld_x = circ_x0;
                  ld_y = circ_y0;
                  ld_z = circ_z0;
                  state_in = ST_CIRC_PHI;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_CIRC_PHI, ST_CIRC_P: begin
            cmd.step = 1'b1;
            cmd.shift = {1'b0, cnt_ff};
            cmd.angle = atan_angle(cnt_ff);
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(CORDIC_STEPS - 1)) begin
               cnt_in = '0;
               pass_in = 1'b0;
               state_in = (state_ff == ST_CIRC_PHI) ? ST_LOAD_P : ST_LOAD_LN;
            end
         end
         ST_LOAD_P: begin
            cmd.load = 1'b1;
            ld_x = c_x;
            ld_y = signed'({{(XW-50){1'b0}}, azk_ff});
            state_in = ST_CIRC_P;
         end
         ST_LOAD_LN: begin
            cnt_in = '0;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == NORM_LAST) begin
               state_in = ST_LOAD_HYP;
            end
         end
         ST_LOAD_HYP: begin
            cmd.load = 1'b1;
            ld_x = hyp_x0;
            ld_y = hyp_y0;
            idx_in = 6'd1;
            rep_in = 1'b0;
            state_in = ST_HYP;
         end
         ST_HYP: begin
            cmd.step = 1'b1;
            cmd.hyp = 1'b1;
            cmd.shift = idx_ff;
            cmd.angle = hyp_angle(idx_ff);
            if ((idx_ff == 6'd4 || idx_ff == 6'd13) && !rep_ff) begin
               rep_in = 1'b1;
            end else begin
               rep_in = 1'b0;
               idx_in = idx_ff + 6'd1;
               if (idx_ff == 6'(CORDIC_STEPS)) begin
                  state_in = ST_LN_DONE;
               end
            end
         end
         ST_LN_DONE: begin
            if (!pass_ff) begin
               pass_in = 1'b1;
               state_in = ST_LOAD_LN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         idx_ff <= '0;
         rep_ff <= 1'b0;
         pass_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         rep_ff <= rep_in;
         pass_ff <= pass_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= mul_a * mul_b;
         unique case (cnt_ff)
            5'd1: srho_ff <= prod_ff;
            5'd2: srho_ff <= srho_ff + prod_ff;
            5'd3: spt_ff <= prod_ff;
            5'd4: spt_ff <= spt_ff + prod_ff;
            5'd5: rho2_ff <= prod_ff;
            5'd6: ptmin2_ff <= prod_ff;
            5'd7: ptmax2_ff <= prod_ff;
            5'd8: azk_ff <= prod_ff[63:14];
            5'd9: azk2_ff <= prod_ff[63:14];
            default: ;
         endcase
         // zero transverse momentum: eta saturates, or is undefined
         if (cnt_ff == MUL_LAST) begin
            phi_ff <= '0;
            eta_ff <= item_ff.mom_z[31] ? -17'sd32768 : 17'sd32768;
            eta_ok_ff <= (item_ff.mom_z != 32'sd0);
         end
      end
      if (state_ff == ST_LOAD_P) begin
         phi_ff <= phi_calc;
         x1_ff <= c_x;
      end
      if (state_ff == ST_LOAD_LN) begin
         norm_ff <= pass_ff ? 64'($unsigned(x1_ff))
                            : 64'($unsigned(c_x)) + 64'(azk2_ff);
         m_ff <= 6'd63;
      end
      // normalize: halve the search window each cycle
      if (state_ff == ST_NORM) begin
         unique case (cnt_ff)
            5'd0: if (norm_ff[63:32] == '0) begin
               norm_ff <= norm_ff << 32; m_ff <= m_ff - 6'd32;
            end
            5'd1: if (norm_ff[63:48] == '0) begin
               norm_ff <= norm_ff << 16; m_ff <= m_ff - 6'd16;
            end
            5'd2: if (norm_ff[63:56] == '0) begin
               norm_ff <= norm_ff << 8; m_ff <= m_ff - 6'd8;
            end
            5'd3: if (norm_ff[63:60] == '0) begin
               norm_ff <= norm_ff << 4; m_ff <= m_ff - 6'd4;
            end
            5'd4: if (norm_ff[63:62] == '0) begin
               norm_ff <= norm_ff << 2; m_ff <= m_ff - 6'd2;
            end
            5'd5: if (!norm_ff[63]) begin
               norm_ff <= norm_ff << 1; m_ff <= m_ff - 6'd1;
            end
            default: ;
         endcase
      end
      if (state_ff == ST_LN_DONE) begin
         if (!pass_ff) begin
            ln_a_ff <= ln_val;
         end else begin
            eta_ff <= eta_calc;
            eta_ok_ff <= 1'b1;
         end
      end
      if (emit) begin
         rsp_payload_ff.keep <= keep_c;
         rsp_payload_ff.vertex_kept <= item_ff.last_of_vertex && any_next;
         rsp_payload_ff.vertex_end <= item_ff.last_of_vertex;
      end
   end

   // output slot and vertex record
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         any_kept_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            any_kept_ff <= item_ff.last_of_vertex ? 1'b0 : any_next;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff) else $error("emitted item not presented");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE) else $error("pop while busy");
   a_vertex_clear: assert property (@(posedge clock) disable iff (reset)
      (emit && item_ff.last_of_vertex) |=> !any_kept_ff)
      else $error("vertex record not cleared");

endmodule
